[hw/rtl/slx_pkg.sv]
`default_nettype none

package slx_pkg;

  // default width of the line counter
  localparam int LINE_BITS_DEF = 16;

  // results one text byte can cause at most
  localparam int MAX_RES = 4;
  localparam int IDX_W   = $clog2(MAX_RES);

  // depth of the queue between front and back (power of two)
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // all results of one input item, all tagged with the same line
  typedef struct packed {
    logic [IDX_W-1:0]              last_idx;
    logic [MAX_RES-1:0][1:0]       kind;
    logic [MAX_RES-1:0][7:0]       chr;
    logic [15:0]                   line;
  } bundle_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

[hw/rtl/slx_front.sv]
`default_nettype none

module slx_front #(
  parameter int LINE_BITS = slx_pkg::LINE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             op_eoi,
  input  wire logic [7:0]       char_in,
  input  wire slx_pkg::qstat_t  qstat,
  output logic                  push,
  output slx_pkg::bundle_t      push_data
);
  import slx_pkg::*;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    M_READY    = 3'd0,
    M_LINECOM  = 3'd1,
    M_BLOCKCOM = 3'd2,
    M_WORD     = 3'd3,
    M_QUOTE    = 3'd4,
    M_MAYBECOM = 3'd5
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic [LINE_BITS-1:0] lc_r, lc_nxt;
  logic [LINE_BITS-1:0] lq_r, lq_nxt;

  logic                 accept;
  logic [2:0]           cnt;
  logic [MAX_RES-1:0][1:0] kinds;
  logic [MAX_RES-1:0][7:0] chars;
  logic [LINE_BITS-1:0] line_sel;
  logic [LINE_BITS+15:0] line_ext;
  logic                 word_run;
  logic                 is_nl, is_sp, is_punct;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  assign is_nl    = (char_in == CH_LF) || (char_in == CH_CR);
  assign is_sp    = (char_in == CH_SPACE) || (char_in == CH_CR) || (char_in == CH_TAB);
  assign is_punct = (char_in == CH_LBRACE) || (char_in == CH_RBRACE) ||
                    (char_in == CH_COLON);

  always_comb begin
    cnt      = 3'd0;
    kinds    = '0;
    chars    = '0;
    mode_nxt = mode_r;
    prev_nxt = prev_r;
    lc_nxt   = lc_r;
    lq_nxt   = lq_r;
    line_sel = lc_r;
    word_run = 1'b0;
    if (op_eoi) begin
      if (mode_r == M_WORD) begin
        kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
      end else if (mode_r == M_QUOTE) begin
        kinds[cnt[IDX_W-1:0]] = KIND_ERR; cnt = cnt + 3'd1;
        line_sel = lq_r;
      end
      mode_nxt = M_READY;
      prev_nxt = 8'h00;
      lc_nxt   = LINE_BITS'(1);
      lq_nxt   = '0;
    end else begin
      prev_nxt = char_in;
      if (char_in == CH_QUOTE) begin
        lq_nxt = lc_r;
      end
      case (mode_r)
        M_LINECOM: begin
          if (is_nl) begin
            kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
            cnt = cnt + 3'd1;
            kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
            mode_nxt = M_READY;
          end
        end
        M_BLOCKCOM: begin
          if (char_in == CH_SLASH && prev_r == CH_STAR) begin
            mode_nxt = M_READY;
          end
        end
        M_MAYBECOM: begin
          if (char_in == CH_SLASH && prev_r == CH_SLASH) begin
            mode_nxt = M_LINECOM;
          end else if (char_in == CH_STAR && prev_r == CH_SLASH) begin
            mode_nxt = M_BLOCKCOM;
          end else begin
            // held-back slash goes out first
            mode_nxt = M_WORD;
            kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = CH_SLASH;
            cnt = cnt + 3'd1;
            word_run = 1'b1;
          end
        end
        M_WORD: begin
          word_run = 1'b1;
        end
        M_QUOTE: begin
          if (char_in != CH_BSLASH) begin
            if (char_in == CH_QUOTE && prev_r == CH_BSLASH) begin
              kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
              cnt = cnt + 3'd1;
            end else if (char_in == CH_QUOTE) begin
              kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
              cnt = cnt + 3'd1;
              kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
              mode_nxt = M_READY;
            end else begin
              if (prev_r == CH_BSLASH) begin
                kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = CH_BSLASH;
                cnt = cnt + 3'd1;
              end
              kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
              cnt = cnt + 3'd1;
            end
          end
        end
        default: begin
          mode_nxt = M_READY;
          if (char_in == CH_SLASH && prev_r == CH_SLASH) begin
            mode_nxt = M_LINECOM;
          end else if (char_in == CH_STAR && prev_r == CH_SLASH) begin
            mode_nxt = M_BLOCKCOM;
          end else if (char_in == CH_QUOTE) begin
            kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
            cnt = cnt + 3'd1;
            mode_nxt = M_QUOTE;
          end else if (is_nl) begin
            kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
            cnt = cnt + 3'd1;
            kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
          end else if (!is_sp) begin
            if (char_in == CH_SLASH) begin
              mode_nxt = M_MAYBECOM;
            end else begin
              kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
              cnt = cnt + 3'd1;
              mode_nxt = M_WORD;
            end
          end
        end
      endcase

      // byte inside a word
      if (word_run) begin
        if (is_nl || (is_punct && !is_sp)) begin
          kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
          kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
          cnt = cnt + 3'd1;
          kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
          mode_nxt = M_READY;
        end else if (is_sp) begin
          kinds[cnt[IDX_W-1:0]] = KIND_END; cnt = cnt + 3'd1;
          mode_nxt = M_READY;
        end else begin
          kinds[cnt[IDX_W-1:0]] = KIND_CHAR; chars[cnt[IDX_W-1:0]] = char_in;
          cnt = cnt + 3'd1;
        end
      end

      // saturating line counter, lf after cr counts once
      if (char_in == CH_CR || (char_in == CH_LF && prev_r != CH_CR)) begin
        if (lc_r != {LINE_BITS{1'b1}}) begin
          lc_nxt = lc_r + 1'b1;
        end
      end
    end
  end

  assign line_ext = {16'h0000, line_sel};

  always_comb begin
    push_data.last_idx = cnt[IDX_W-1:0] - 1'b1;
    push_data.kind     = kinds;
    push_data.chr      = chars;
    push_data.line     = line_ext[15:0];
  end

  assign push = accept && (cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_READY;
      prev_r <= 8'h00;
      lc_r   <= LINE_BITS'(1);
      lq_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      prev_r <= prev_nxt;
      lc_r   <= lc_nxt;
      lq_r   <= lq_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/slx_queue.sv]
`default_nettype none

module slx_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire slx_pkg::bundle_t  push_data,
  input  wire logic              pop,
  output slx_pkg::bundle_t       head,
  output slx_pkg::qstat_t        qstat
);
  import slx_pkg::*;

  bundle_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push = push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  always_comb begin
    qstat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
    qstat.empty = (cnt_r == '0);
  end

  assign head = entry_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/slx_back.sv]
`default_nettype none

module slx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire slx_pkg::bundle_t  head,
  input  wire slx_pkg::qstat_t   qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_char,
  output logic [15:0]            out_line,
  output logic                   out_last
);
  import slx_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic             valid_r;
  logic [1:0]       kind_r;
  logic [7:0]       char_r;
  logic [15:0]      line_r;
  logic             last_r;
  logic             load, take, at_end;

  assign load   = !valid_r || out_ready;
  assign take   = load && !qstat.empty;
  assign at_end = (idx_r == head.last_idx);
  assign pop    = take && at_end;

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= head.kind[idx_r];
      char_r <= head.chr[idx_r];
      line_r <= head.line;
      last_r <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !qstat.empty;
      if (take) begin
        idx_r <= at_end ? '0 : idx_r + 1'b1;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_char  = char_r;
  assign out_line  = line_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

[hw/rtl/script_lexer_with_comments_top.sv]
`default_nettype none

// channel | dir | handshake           | payload
// in      | in  | in_tvalid/in_tready | in_tuser = operation, in_tdata = char_in
// out     | out | out_tvalid/out_tready | out_tuser = kind, out_tdata = line:out_char,
//         |     |                     | out_tlast = last
//
// one item per cycle is taken while the queue has room; the state update
// is combinational compare-and-select logic on the byte and mode
// results leave one per cycle from the output register while out_tready is high;
// the back side walks the results of an item (up to four) in order
// the four-entry queue absorbs the bursts; in_tready falls only when it is full
// synchronous active-low reset puts the lexer in ready mode, line 1

module script_lexer_with_comments_top #(
  parameter int LINE_BITS = slx_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tuser,   // [0] operation (1 = end of input)
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_char, [23:8] line
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last result of the item
);
  import slx_pkg::*;

  bundle_t     push_data;   // results of one item, front to queue
  bundle_t     head;        // oldest queued item
  qstat_t      qstat;
  logic        push;
  logic        pop;
  logic [7:0]  res_char;
  logic [15:0] res_line;

  // front: classifies each byte and updates mode, line counters
  slx_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op_eoi    (in_tuser),
    .char_in   (in_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // short queue of result groups decouples the two sides
  slx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: walks each group one result at a time into the output register
  slx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_char  (res_char),
    .out_line  (res_line),
    .out_last  (out_tlast)
  );

  assign out_tdata = {res_line, res_char};

endmodule

`default_nettype wire

[tb/sv/lexer_checker.sv]
`default_nettype none

// watches both channels of the lexer, predicts every result of an accepted
// item and compares each accepted result with the oldest prediction
module lexer_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tuser,   // [0] operation (1 = end of input)
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // [7:0] out_char, [23:8] line
  input  wire logic [1:0]  out_tuser,  // [1:0] kind
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending,
  output int               result_count,
  output int               error_count
);
  import slx_pkg::*;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [15:0] LINE_TOP = 16'hFFFF;
  localparam int          MAX_SHOWN = 40;

  typedef enum logic [2:0] {
    LX_READY     = 3'd0,
    LX_LINE_COM  = 3'd1,
    LX_BLOCK_COM = 3'd2,
    LX_WORD      = 3'd3,
    LX_QUOTE     = 3'd4,
    LX_MAYBE_COM = 3'd5
  } lex_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  chr;
    logic [15:0] line;
    logic        last;
  } token_res_t;

  lex_mode_t   lex_mode;
  logic [7:0]  prev_byte;
  logic [15:0] line_cnt;
  logic [15:0] quote_line;
  token_res_t  token_q[$];
  int          step_n;

  int n_fail    = 0;
  int n_pending = 0;
  int n_results = 0;
  int n_errors  = 0;

  assign fail_count   = n_fail;
  assign pending      = n_pending;
  assign result_count = n_results;
  assign error_count  = n_errors;

  task clear_state();
    lex_mode   = LX_READY;
    prev_byte  = 8'h00;
    line_cnt   = 16'd1;
    quote_line = 16'd0;
  endtask

  task put(input logic [1:0] kind, input logic [7:0] chr, input logic [15:0] line);
    token_res_t r;
    r.kind = kind;
    r.chr  = (kind == KIND_CHAR) ? chr : 8'h00;
    r.line = line;
    r.last = 1'b0;
    token_q.insert(token_q.size(), r);
    step_n++;
  endtask

  // byte seen while a word is open
  task word_char(input logic [7:0] c);
    if (c == CH_LF || c == CH_CR || c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON) begin
      put(KIND_END, 8'h00, line_cnt);
      put(KIND_CHAR, c, line_cnt);
      put(KIND_END, 8'h00, line_cnt);
      lex_mode = LX_READY;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      put(KIND_END, 8'h00, line_cnt);
      lex_mode = LX_READY;
    end else begin
      put(KIND_CHAR, c, line_cnt);
    end
  endtask

  task lex_step(input logic end_of_text, input logic [7:0] c);
    logic [7:0] lastc;
    token_res_t r;
    int         tail;
    step_n = 0;
    if (end_of_text) begin
      if (lex_mode == LX_WORD) begin
        put(KIND_END, 8'h00, line_cnt);
      end else if (lex_mode == LX_QUOTE) begin
        put(KIND_ERR, 8'h00, quote_line);
      end
      clear_state();
    end else begin
      lastc     = prev_byte;
      prev_byte = c;
      if (c == CH_QUOTE) quote_line = line_cnt;
      case (lex_mode)
        LX_LINE_COM: begin
          if (c == CH_LF || c == CH_CR) begin
            put(KIND_CHAR, c, line_cnt);
            put(KIND_END, 8'h00, line_cnt);
            lex_mode = LX_READY;
          end
        end
        LX_BLOCK_COM: begin
          if (c == CH_SLASH && lastc == CH_STAR) lex_mode = LX_READY;
        end
        LX_MAYBE_COM: begin
          if (c == CH_SLASH && lastc == CH_SLASH) begin
            lex_mode = LX_LINE_COM;
          end else if (c == CH_STAR && lastc == CH_SLASH) begin
            lex_mode = LX_BLOCK_COM;
          end else begin
            lex_mode = LX_WORD;
            put(KIND_CHAR, CH_SLASH, line_cnt);
            word_char(c);
          end
        end
        LX_WORD: word_char(c);
        LX_QUOTE: begin
          if (c != CH_BSLASH) begin
            if (c == CH_QUOTE && lastc == CH_BSLASH) begin
              put(KIND_CHAR, c, line_cnt);
            end else if (c == CH_QUOTE) begin
              put(KIND_CHAR, c, line_cnt);
              put(KIND_END, 8'h00, line_cnt);
              lex_mode = LX_READY;
            end else begin
              if (lastc == CH_BSLASH) put(KIND_CHAR, CH_BSLASH, line_cnt);
              put(KIND_CHAR, c, line_cnt);
            end
          end
        end
        default: begin
          lex_mode = LX_READY;
          if (c == CH_SLASH && lastc == CH_SLASH) begin
            lex_mode = LX_LINE_COM;
          end else if (c == CH_STAR && lastc == CH_SLASH) begin
            lex_mode = LX_BLOCK_COM;
          end else if (c == CH_QUOTE) begin
            put(KIND_CHAR, c, line_cnt);
            lex_mode = LX_QUOTE;
          end else if (c == CH_LF || c == CH_CR) begin
            put(KIND_CHAR, c, line_cnt);
            put(KIND_END, 8'h00, line_cnt);
          end else if (c != CH_SPACE && c != CH_TAB) begin
            if (c == CH_SLASH) begin
              lex_mode = LX_MAYBE_COM;
            end else begin
              put(KIND_CHAR, c, line_cnt);
              lex_mode = LX_WORD;
            end
          end
        end
      endcase
      // crlf counts once, the counter sticks at its top
      if (c == CH_CR || (c == CH_LF && lastc != CH_CR)) begin
        if (line_cnt != LINE_TOP) line_cnt = line_cnt + 16'd1;
      end
    end
    // newest prediction of this item carries the last flag
    if (step_n > 0) begin
      tail = token_q.size() - 1;
      r = token_q[tail];
      r.last = 1'b1;
      token_q[tail] = r;
    end
  endtask

  task report(input string msg);
    n_fail++;
    // keep the log short when everything goes wrong
    if (n_fail <= MAX_SHOWN) $display("mismatch at %0t, result %0d: %s", $time, n_results, msg);
  endtask

  always @(posedge clk) begin
    token_res_t want;
    if (!rst_n) begin
      clear_state();
      token_q.delete();
    end else begin
      if (in_tvalid && in_tready) lex_step(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        n_results++;
        if (out_tuser == KIND_ERR) n_errors++;
        if (token_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d char %0h line %0d",
                           out_tuser, out_tdata[7:0], out_tdata[23:8]));
        end else begin
          want = token_q.pop_front();
          if (out_tuser !== want.kind)
            report($sformatf("kind got %0d want %0d", out_tuser, want.kind));
          if (out_tdata[7:0] !== want.chr)
            report($sformatf("char got %0h want %0h", out_tdata[7:0], want.chr));
          if (out_tdata[23:8] !== want.line)
            report($sformatf("line got %0d want %0d", out_tdata[23:8], want.line));
          if (out_tlast !== want.last)
            report($sformatf("last got %0b want %0b", out_tlast, want.last));
        end
      end
    end
    n_pending = token_q.size();
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

// stimulus and verdict for the script lexer; all prediction and comparison
// lives in lexer_checker, which sits beside the block on the same wires
module testbench;
  import slx_pkg::*;

  // operation codes carried on in_tuser
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int RAND_ITEMS   = 265;
  localparam int CALM_ITEMS   = 45;     // tail of the random part with no idling
  localparam int HOLD_CYCLES  = 64;     // long output stall, well past the queue depth
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT   = 1000;   // cycles with no handshake at all

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = OP_TEXT;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int n_fail;
  int n_pending;
  int n_results;
  int n_errors;

  int items_sent = 0;
  int ends_sent  = 0;
  int idle_run   = 0;

  // idling switches: src_idle steers the sender, sink_idle and hold_req the receiver
  bit src_idle  = 1'b0;
  bit sink_idle = 1'b0;
  bit hold_req  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  script_lexer_with_comments_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lexer_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (n_fail),
    .pending      (n_pending),
    .result_count (n_results),
    .error_count  (n_errors)
  );

  // offer one item and hold it until the block takes it; an optional idle
  // burst goes in front of it
  task automatic send_item(input logic op, input logic [7:0] chr);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= chr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_TEXT, s[i]);
  endtask

  // the data byte is don't-care at end of input, so it is random
  task automatic send_end();
    send_item(OP_END, 8'($urandom_range(0, 255)));
    ends_sent++;
  endtask

  // mostly letters, sometimes any byte at all
  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] separator();
    case ($urandom_range(0, 6))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_LF;
      4:       return CH_LBRACE;
      5:       return CH_RBRACE;
      default: return CH_COLON;
    endcase
  endfunction

  // one well-formed piece of script text with random content, or noise
  task automatic send_fragment();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(0, 5);
    if (pick < 30) begin
      // word and whatever ends it
      repeat (n + 1) send_item(OP_TEXT, word_byte());
      send_item(OP_TEXT, separator());
    end else if (pick < 45) begin
      // quoted string with escapes; now and then left open
      send_item(OP_TEXT, CH_QUOTE);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_TEXT, CH_BSLASH);
          send_item(OP_TEXT, ($urandom_range(0, 1) != 0) ? CH_QUOTE : word_byte());
        end else begin
          send_item(OP_TEXT, word_byte());
        end
      end
      if ($urandom_range(0, 7) != 0) send_item(OP_TEXT, CH_QUOTE);
    end else if (pick < 55) begin
      // line comment up to a newline
      send_text("//");
      repeat (n) send_item(OP_TEXT, 8'($urandom_range(0, 255)));
      send_item(OP_TEXT, ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
    end else if (pick < 65) begin
      // block comment, stars and slashes inside, newlines counted
      send_text("/*");
      repeat (n) begin
        case ($urandom_range(0, 4))
          0:       send_item(OP_TEXT, CH_STAR);
          1:       send_item(OP_TEXT, CH_SLASH);
          2:       send_item(OP_TEXT, CH_CR);
          3:       send_item(OP_TEXT, CH_LF);
          default: send_item(OP_TEXT, 8'($urandom_range(0, 255)));
        endcase
      end
      send_text("*/");
    end else if (pick < 72) begin
      // slash that turns out to start a word or stand alone
      send_item(OP_TEXT, CH_SLASH);
      send_item(OP_TEXT, ($urandom_range(0, 1) != 0) ? word_byte() : separator());
    end else if (pick < 80) begin
      case ($urandom_range(0, 2))
        0:       send_text("\015\n");
        1:       send_item(OP_TEXT, CH_LF);
        default: send_item(OP_TEXT, CH_CR);
      endcase
    end else if (pick < 86) begin
      send_end();
    end else begin
      repeat ((n % 3) + 1) send_item(OP_TEXT, 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: ready by default, random stall bursts, one long hold on request
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: a run where nothing moves for too long has hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results still due",
               IDLE_LIMIT, n_pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int rand_goal;
    bit hold_done;
    hold_done = 1'b0;

    // reset held low at start, then released at a clock edge
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed text: token splitting, escapes, comments, end-of-input cases
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_text("a{b:} ");            // brace and colon split a word, space ends it
    send_text("\015\n");            // cr lf pair counts one line
    send_text("\"\\\"\\n\"");       // escaped quote, escaped letter, closing quote
    send_text("//\n");              // empty line comment
    send_text("/**/*/");            // star right after a closing slash reopens a comment
    send_item(OP_TEXT, 8'hFF);      // all-ones byte opens a word
    send_item(OP_TEXT, 8'h00);
    send_end();                     // open word gets its end mark
    send_text("\"");
    send_end();                     // open quote reports an error
    send_text("/");
    send_end();                     // held-back lone slash is dropped

    // empty block comment, a word ended by cr lf, then an open quote at
    // end of input, all without idling
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_text("/*");
    send_text("*/x\015\n\"");
    send_end();

    // random text; one long output hold in the middle, calm tail at the end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    rand_goal = items_sent + RAND_ITEMS;
    while (items_sent < rand_goal) begin
      if (!hold_done && items_sent > rand_goal - RAND_ITEMS + 100) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent > rand_goal - CALM_ITEMS) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else begin
        if ($urandom_range(0, 9) == 0) src_idle = !src_idle;
        if ($urandom_range(0, 9) == 0) sink_idle = !sink_idle;
      end
      send_fragment();
    end
    send_end();
    in_tvalid <= 1'b0;

    // wait for the last results, then a quiet drain time
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items in, %0d of them end of input, %0d results checked, %0d quote errors",
             items_sent, ends_sent, n_results, n_errors);
    $display("run: comments, quotes, escapes and word splits, one %0d-cycle output hold",
             HOLD_CYCLES);
    if (n_fail == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_fail, n_pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
